// File: rtl/core/rtca_pkg.sv
// rtca_pkg: shared types and constants for the rtc alarm / general register block
// command and status codes, input item and result structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rtca_pkg;

    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int TICK_W    = 47;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 8;
    localparam int SEC_SHIFT = 15;

    localparam logic [TICK_W-1:0] SEC_TICKS  = TICK_W'(1) << SEC_SHIFT;
    localparam logic [TICK_W-1:0] WRAP_LIMIT = TICK_W'({WORD_W{1'b1}}) << SEC_SHIFT;

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_TIME_SET  = 3'd1,
        CMD_TIME_GET  = 3'd2,
        CMD_ALARM_SET = 3'd3,
        CMD_ARM_ROLL  = 3'd4,
        CMD_REG_WRITE = 3'd5,
        CMD_REG_READ  = 3'd6,
        CMD_BTN_READ  = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_REG     = 2'd1,
        ST_ALARM_PAST = 2'd2
    } status_t;

    typedef struct packed {
        cmd_t              cmd;
        logic              tick_units;
        logic [TICK_W-1:0] data;
        logic              alarm_on;
        logic [IDX_W-1:0]  reg_index;
    } cmd_item_t;

    typedef struct packed {
        status_t           status;
        logic [TICK_W-1:0] read_data;
        logic              alarm_event;
        logic              rollover_event;
        logic              button_event;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/rtca_core.sv
// rtca_core: clock count, alarm, rollover arm, button and general register state
// computes one result per command and updates state on fire
// depends on rtca_pkg
`timescale 1ns / 1ps
`default_nettype none

module rtca_core
    import rtca_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire cmd_item_t item,
    output result_t        res
);

    logic [TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [TICK_W-1:0] alarm_ticks_reg, alarm_ticks_next;
    logic              alarm_enabled_reg, alarm_enabled_next;
    logic              rollover_armed_reg, rollover_armed_next;
    logic              button_reg, button_next;
    logic [WORD_W-1:0] gen_regs_reg [NUM_REGS];

    logic [TICK_W:0]    tick_sum;
    logic [TICK_W-1:0]  sec_ticks;
    logic               idx_ok;
    logic               reg_we;
    logic [REG_IDX_W-1:0] idx;

    assign sec_ticks = {item.data[WORD_W-1:0], {SEC_SHIFT{1'b0}}};
    assign tick_sum  = {1'b0, tick_count_reg} + {1'b0, SEC_TICKS};
    assign idx_ok    = item.reg_index < IDX_W'(NUM_REGS);
    assign idx       = item.reg_index[REG_IDX_W-1:0];

    always_comb
    begin
        tick_count_next     = tick_count_reg;
        alarm_ticks_next    = alarm_ticks_reg;
        alarm_enabled_next  = alarm_enabled_reg;
        rollover_armed_next = rollover_armed_reg;
        button_next         = button_reg;
        reg_we              = 1'b0;
        res                 = '0;
        res.status          = ST_OK;
        case (item.cmd)
            CMD_TICK:
            begin
                if (tick_sum > {1'b0, WRAP_LIMIT})
                begin
                    tick_count_next = '0;
                    if (rollover_armed_reg)
                    begin
                        rollover_armed_next = 1'b0;
                        res.rollover_event  = 1'b1;
                    end
                end
                else
                begin
                    tick_count_next = tick_sum[TICK_W-1:0];
                end
                res.alarm_event  = alarm_enabled_reg && (tick_count_next >= alarm_ticks_reg);
                button_next      = !button_reg;
                res.button_event = !button_reg;
            end
            CMD_TIME_SET:
            begin
                tick_count_next = item.tick_units ? item.data : sec_ticks;
            end
            CMD_TIME_GET:
            begin
                res.read_data = item.tick_units ? tick_count_reg
                                                : (tick_count_reg >> SEC_SHIFT);
            end
            CMD_ALARM_SET:
            begin
                if (item.alarm_on)
                begin
                    if (sec_ticks <= tick_count_reg)
                    begin
                        res.status = ST_ALARM_PAST;
                    end
                    else
                    begin
                        alarm_ticks_next   = sec_ticks;
                        alarm_enabled_next = 1'b1;
                    end
                end
                else
                begin
                    alarm_enabled_next = 1'b0;
                end
            end
            CMD_ARM_ROLL:
            begin
                rollover_armed_next = 1'b1;
            end
            CMD_REG_WRITE:
            begin
                if (idx_ok)
                    reg_we = 1'b1;
                else
                    res.status = ST_NO_REG;
            end
            CMD_REG_READ:
            begin
                if (idx_ok)
                    res.read_data = TICK_W'(gen_regs_reg[idx]);
                else
                    res.status = ST_NO_REG;
            end
            default:
            begin
                res.read_data = TICK_W'(button_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg     <= '0;
            alarm_ticks_reg    <= '0;
            alarm_enabled_reg  <= 1'b0;
            rollover_armed_reg <= 1'b0;
            button_reg         <= 1'b0;
        end
        else if (fire)
        begin
            tick_count_reg     <= tick_count_next;
            alarm_ticks_reg    <= alarm_ticks_next;
            alarm_enabled_reg  <= alarm_enabled_next;
            rollover_armed_reg <= rollover_armed_next;
            button_reg         <= button_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                gen_regs_reg[i] <= '0;
        end
        else if (fire && reg_we)
        begin
            gen_regs_reg[idx] <= item.data[WORD_W-1:0];
        end
    end

`ifndef SYNTH
    a_enable_needs_future: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.cmd == CMD_ALARM_SET && item.alarm_on && res.status == ST_OK)
        |=> (alarm_enabled_reg && alarm_ticks_reg > $past(tick_count_reg)))
        else $error("alarm enabled at a time not in the future");
    a_roll_clears_arm: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.rollover_event) |=> !rollover_armed_reg && tick_count_reg == '0)
        else $error("rollover event without wrap or arm clear");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.cmd == CMD_TICK) |=> tick_count_reg <= WRAP_LIMIT)
        else $error("tick left count past wrap limit");
`endif

endmodule

`default_nettype wire

// File: rtl/core/rtc_alarm_gpr_block.sv
// rtc_alarm_gpr_block: top level with input register, command core and two-entry result buffer
// a result goes through the input register, then the result buffer, to the output
// throughput: one command per cycle; input stalls only when the input register and both
// result slots are full
// reset: rst_n clears count, alarm, arm, button, general registers and all valid flags
// depends on rtca_pkg and rtca_core
`timescale 1ns / 1ps
`default_nettype none

module rtc_alarm_gpr_block
    import rtca_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        cmd,
    input  wire logic              in_tick_units,
    input  wire logic [TICK_W-1:0] data_value,
    input  wire logic              alarm_on,
    input  wire logic [IDX_W-1:0]  reg_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [TICK_W-1:0]      read_data,
    output logic                   alarm_event,
    output logic                   rollover_event,
    output logic                   button_event
);

    cmd_item_t item_reg;
    logic      item_valid_reg;
    result_t   head_reg, skid_reg, core_res;
    logic      head_valid_reg, skid_valid_reg;
    logic      fire, in_xfer, pop;

    assign fire     = item_valid_reg && !skid_valid_reg;
    assign in_stall = item_valid_reg && !fire;
    assign in_xfer  = in_valid && !in_stall;
    assign pop      = head_valid_reg && !out_stall;

    rtca_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_xfer || fire)
            item_valid_reg <= in_xfer;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.cmd        <= cmd_t'(cmd);
            item_reg.tick_units <= in_tick_units;
            item_reg.data       <= data_value;
            item_reg.alarm_on   <= alarm_on;
            item_reg.reg_index  <= reg_index;
        end
    end

    // result buffer: head drives the port, skid catches a transfer while head is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (pop)
                    skid_valid_reg <= 1'b0;
            end
            else if (fire)
            begin
                head_valid_reg <= 1'b1;
                skid_valid_reg <= head_valid_reg && !pop;
            end
            else if (pop)
            begin
                head_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                head_reg <= skid_reg;
        end
        else if (fire)
        begin
            if (!head_valid_reg || pop)
                head_reg <= core_res;
            else
                skid_reg <= core_res;
        end
    end

    assign out_valid      = head_valid_reg;
    assign status         = head_reg.status;
    assign read_data      = head_reg.read_data;
    assign alarm_event    = head_reg.alarm_event;
    assign rollover_event = head_reg.rollover_event;
    assign button_event   = head_reg.button_event;

`ifndef SYNTH
    a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid slot full with empty head");
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (item_valid_reg && skid_valid_reg))
        else $error("input stalled with room in the result buffer");
    a_skid_refills_head: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> (head_valid_reg && !skid_valid_reg))
        else $error("buffered result lost after head transfer");
    a_events_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (alarm_event || rollover_event || button_event))
        |-> (status == ST_OK && read_data == '0))
        else $error("event result carries status or data");
`endif

endmodule

`default_nettype wire
